@@ rtl/pfle_pkg.sv @@
// Shared types and constants for the paged frame buffer line engine.
// No dependencies; imported by page_framebuffer_line_engine.
package pfle_pkg;

   localparam int COLUMNS_DEF = 128;
   localparam int PAGES_DEF   = 8;

   localparam logic [2:0] ACT_PIXEL = 3'd0;
   localparam logic [2:0] ACT_LINE  = 3'd1;
   localparam logic [2:0] ACT_WRITE = 3'd2;
   localparam logic [2:0] ACT_READ  = 3'd3;
   localparam logic [2:0] ACT_CLEAR = 3'd4;

   typedef enum logic [1:0] {
      ST_SWEEP,
      ST_IDLE,
      ST_FETCH,
      ST_UPDATE
   } state_type;

   typedef enum logic [1:0] {
      OP_PIXEL,
      OP_LINE,
      OP_WRITE,
      OP_READ
   } op_type;

endpackage

@@ rtl/page_framebuffer_line_engine.sv @@
// Top level of the paged monochrome frame buffer with pixel, line, byte and clear commands.
// Depends on pfle_pkg for the state and operation types and the command codes.
//
//  channel    ports                          transfer when
//  --------   ----------------------------   ---------------------------------
//  command    start, busy, req_*             start high while busy is low
//  result     rsp_valid, rsp_status,          rsp_valid high, one cycle only
//             rsp_read_byte
//
// Every on-screen pixel and byte write is a read-modify-write of the single-port frame
// memory: the addressed byte is fetched in ST_FETCH and merged and written back in
// ST_UPDATE; a byte read fetches in the same way but writes nothing back. Off-screen
// targets pass through ST_FETCH alone. A line visits max(|dx|,|dy|)+1 points, each
// handled like a pixel. A clear walks the memory one byte per cycle over all
// PAGES*COLUMNS bytes. After reset the same pass runs without a result, and busy
// stays high until it ends. The result register is loaded when the command finishes
// and the receiver cannot stall it; busy is low in the result cycle, so the next
// command may be taken there. Unused codes answer the cycle after transfer.
module page_framebuffer_line_engine
   import pfle_pkg::*;
#(
   parameter int COLUMNS = COLUMNS_DEF,
   parameter int PAGES   = PAGES_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  logic [2:0] req_action,
   input  logic [7:0] req_x_start,
   input  logic [7:0] req_y_start,
   input  logic [7:0] req_x_end,
   input  logic [7:0] req_y_end,
   input  logic [7:0] req_byte_data,
   input  logic [2:0] req_bit_low,
   input  logic [2:0] req_bit_high,
   input  logic       req_invert,
   output logic       rsp_valid,
   output logic       rsp_status,
   output logic [7:0] rsp_read_byte
);

   localparam int DEPTH = PAGES * COLUMNS;
   localparam int AW    = $clog2(DEPTH);

   // Frame memory: byte page*COLUMNS+column, bit 0 is the top row of the page.
   logic [7:0] mem [DEPTH];
   logic [7:0] mem_q_ff;
   logic          mem_re, mem_we;
   logic [AW-1:0] mem_addr;
   logic [7:0]    mem_wdata;

   state_type state_ff, state_in;
   op_type    op_ff, op_in;

   logic [AW-1:0] sweep_cnt_ff, sweep_cnt_in;
   logic          sweep_reply_ff, sweep_reply_in;
   logic [AW-1:0] addr_ff, addr_in;
   logic [7:0]    cur_x_ff, cur_x_in, cur_y_ff, cur_y_in;
   logic [7:0]    end_x_ff, end_x_in, end_y_ff, end_y_in;
   logic [7:0]    dx_ff, dx_in, dy_ff, dy_in;
   logic          sx_neg_ff, sx_neg_in, sy_neg_ff, sy_neg_in, x_major_ff, x_major_in;
   logic signed [10:0] err_ff, err_in;
   logic [7:0]    data_ff, data_in, mask_ff, mask_in;
   logic          clear_ff, clear_in;
   logic          rsp_valid_ff, rsp_valid_in, rsp_status_ff, rsp_status_in;
   logic [7:0]    rsp_read_byte_ff, rsp_read_byte_in;

   logic          accept;
   logic [7:0]    page_sel;
   logic          in_range;
   logic [15:0]   addr_wide;
   logic          last_point;
   logic [7:0]    next_x, next_y, step_x, step_y;
   logic signed [10:0] err_add, next_err;
   logic signed [11:0] err_dbl;
   logic          minor_step;
   logic [7:0]    chg, pix_data, byte_mask;

   assign accept = start && !busy;
   assign busy   = (state_ff != ST_IDLE);

   // Pixel commands address by row; byte commands carry the page directly.
   assign page_sel = (op_ff == OP_PIXEL || op_ff == OP_LINE) ? {3'b000, cur_y_ff[7:3]}
                                                             : cur_y_ff;
   assign in_range = ({1'b0, page_sel} < 9'(PAGES)) && ({1'b0, cur_x_ff} < 9'(COLUMNS));
   assign addr_wide = 16'(page_sel) * 16'(COLUMNS) + 16'(cur_x_ff);

   // Bresenham step along the major axis; a point at the major end is the last one.
   assign step_x  = sx_neg_ff ? cur_x_ff - 8'd1 : cur_x_ff + 8'd1;
   assign step_y  = sy_neg_ff ? cur_y_ff - 8'd1 : cur_y_ff + 8'd1;
   assign err_add = err_ff + $signed({3'b000, x_major_ff ? dy_ff : dx_ff});
   assign err_dbl = {err_add, 1'b0};
   assign minor_step = err_dbl >= $signed({4'b0000, x_major_ff ? dx_ff : dy_ff});
   assign next_err = minor_step ? err_add - $signed({3'b000, x_major_ff ? dx_ff : dy_ff})
                                : err_add;
   assign next_x = x_major_ff ? step_x : (minor_step ? step_x : cur_x_ff);
   assign next_y = x_major_ff ? (minor_step ? step_y : cur_y_ff) : step_y;
   assign last_point = (op_ff != OP_LINE) ||
                       (x_major_ff ? (cur_x_ff == end_x_ff) : (cur_y_ff == end_y_ff));

   assign pix_data = {8{~clear_ff}};
   assign chg = (op_ff == OP_PIXEL || op_ff == OP_LINE) ? (8'h01 << cur_y_ff[2:0]) : mask_ff;

   always_comb begin
      for (int i = 0; i < 8; i++) begin
         byte_mask[i] = (3'(i) >= req_bit_low) && (3'(i) <= req_bit_high);
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_SWEEP: begin
            if (sweep_cnt_ff == AW'(DEPTH - 1)) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (accept) begin
               case (req_action)
                  ACT_PIXEL, ACT_LINE, ACT_WRITE, ACT_READ: state_in = ST_FETCH;
                  ACT_CLEAR: state_in = ST_SWEEP;
                  default:   state_in = ST_IDLE;
               endcase
            end
         end
         ST_FETCH: begin
            if (in_range)        state_in = ST_UPDATE;
            else if (last_point) state_in = ST_IDLE;
         end
         ST_UPDATE: begin
            state_in = last_point ? ST_IDLE : ST_FETCH;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Outputs and datapath.
   always_comb begin
      mem_re = 1'b0;
      mem_we = 1'b0;
      mem_addr = addr_ff;
      mem_wdata = 8'h00;
      op_in = op_ff;
      sweep_cnt_in = sweep_cnt_ff;
      sweep_reply_in = sweep_reply_ff;
      addr_in = addr_ff;
      cur_x_in = cur_x_ff;
      cur_y_in = cur_y_ff;
      end_x_in = end_x_ff;
      end_y_in = end_y_ff;
      dx_in = dx_ff;
      dy_in = dy_ff;
      sx_neg_in = sx_neg_ff;
      sy_neg_in = sy_neg_ff;
      x_major_in = x_major_ff;
      err_in = err_ff;
      data_in = data_ff;
      mask_in = mask_ff;
      clear_in = clear_ff;
      rsp_valid_in = 1'b0;
      rsp_status_in = 1'b0;
      rsp_read_byte_in = 8'h00;
      case (state_ff)
         ST_SWEEP: begin
            mem_we = 1'b1;
            mem_addr = sweep_cnt_ff;
            sweep_cnt_in = sweep_cnt_ff + AW'(1);
            if (sweep_cnt_ff == AW'(DEPTH - 1)) begin
               rsp_valid_in = sweep_reply_ff;
               sweep_cnt_in = '0;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               cur_x_in = req_x_start;
               cur_y_in = req_y_start;
               end_x_in = req_x_end;
               end_y_in = req_y_end;
               sx_neg_in = req_x_end < req_x_start;
               sy_neg_in = req_y_end < req_y_start;
               dx_in = (req_x_end < req_x_start) ? req_x_start - req_x_end
                                                 : req_x_end - req_x_start;
               dy_in = (req_y_end < req_y_start) ? req_y_start - req_y_end
                                                 : req_y_end - req_y_start;
               x_major_in = dx_in > dy_in;
               err_in = '0;
               data_in = req_invert ? ~req_byte_data : req_byte_data;
               mask_in = byte_mask;
               clear_in = req_invert;
               sweep_cnt_in = '0;
               sweep_reply_in = 1'b1;
               case (req_action)
                  ACT_PIXEL: op_in = OP_PIXEL;
                  ACT_LINE:  op_in = OP_LINE;
                  ACT_WRITE: op_in = OP_WRITE;
                  ACT_READ:  op_in = OP_READ;
                  ACT_CLEAR: op_in = op_ff;
                  default:   rsp_valid_in = 1'b1;
               endcase
            end
         end
         ST_FETCH: begin
            addr_in = addr_wide[AW-1:0];
            mem_addr = addr_wide[AW-1:0];
            mem_re = in_range;
            if (!in_range) begin
               cur_x_in = next_x;
               cur_y_in = next_y;
               err_in = next_err;
               if (last_point) begin
                  rsp_valid_in = 1'b1;
                  rsp_status_in = (op_ff != OP_LINE);
               end
            end
         end
         ST_UPDATE: begin
            mem_we = (op_ff != OP_READ);
            mem_wdata = (mem_q_ff & ~chg) |
                        (((op_ff == OP_WRITE) ? data_ff : pix_data) & chg);
            cur_x_in = next_x;
            cur_y_in = next_y;
            err_in = next_err;
            if (last_point) begin
               rsp_valid_in = 1'b1;
               rsp_read_byte_in = (op_ff == OP_READ) ? mem_q_ff : 8'h00;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_addr] <= mem_wdata;
      if (mem_re) mem_q_ff <= mem[mem_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_SWEEP;
         sweep_cnt_ff <= '0;
         sweep_reply_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         sweep_cnt_ff <= sweep_cnt_in;
         sweep_reply_ff <= sweep_reply_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff <= op_in;
      addr_ff <= addr_in;
      cur_x_ff <= cur_x_in;
      cur_y_ff <= cur_y_in;
      end_x_ff <= end_x_in;
      end_y_ff <= end_y_in;
      dx_ff <= dx_in;
      dy_ff <= dy_in;
      sx_neg_ff <= sx_neg_in;
      sy_neg_ff <= sy_neg_in;
      x_major_ff <= x_major_in;
      err_ff <= err_in;
      data_ff <= data_in;
      mask_ff <= mask_in;
      clear_ff <= clear_in;
      rsp_status_ff <= rsp_status_in;
      rsp_read_byte_ff <= rsp_read_byte_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_read_byte = rsp_read_byte_ff;

   // A result is only ever shown with the engine ready for the next command.
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset) rsp_valid |-> !busy)
      else $error("result shown while busy");

   // Memory is written only while sweeping or in the write-back cycle.
   a_we_state: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (state_ff == ST_SWEEP || state_ff == ST_UPDATE))
      else $error("memory write outside sweep or write-back");

   // A write-back always follows a fetch that issued a read.
   a_fetch_before_update: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_UPDATE) |-> $past(mem_re))
      else $error("write-back without a preceding read");

   // Read data appears only on a completed read command.
   a_rd_only_read: assert property (@(posedge clock) disable iff (reset)
      (rsp_read_byte != 8'h00) |-> (rsp_valid && $past(op_ff == OP_READ)))
      else $error("read byte on a non-read result");

endmodule

@@ tb/tb_page_framebuffer_line_engine.sv @@
// Self-checking testbench for page_framebuffer_line_engine: directed and random commands.
// Depends on pfle_pkg for command codes; predicts frame store contents and every result.
module tb_page_framebuffer_line_engine
   import pfle_pkg::*;
();

   localparam int COLS  = COLUMNS_DEF;
   localparam int PGS   = PAGES_DEF;
   localparam int ROWS  = PGS * 8;
   // No transfer for this many cycles ends the run. The longest quiet stretch is the
   // clearing pass after reset or a clear command, or a 256-pixel line.
   localparam int QUIET_LIMIT = 20 * PGS * COLS + 4000;

   typedef struct packed {
      logic [2:0] action;
      logic [7:0] x_start;
      logic [7:0] y_start;
      logic [7:0] x_end;
      logic [7:0] y_end;
      logic [7:0] byte_data;
      logic [2:0] bit_low;
      logic [2:0] bit_high;
      logic       invert;
   } command_type;

   typedef struct packed {
      logic       status;
      logic [7:0] read_byte;
   } answer_type;

   localparam int CMD_W = $bits(command_type);

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       start = 1'b0;
   logic       busy;
   logic [2:0] req_action = '0;
   logic [7:0] req_x_start = '0, req_y_start = '0, req_x_end = '0, req_y_end = '0;
   logic [7:0] req_byte_data = '0;
   logic [2:0] req_bit_low = '0, req_bit_high = '0;
   logic       req_invert = 1'b0;
   logic       rsp_valid, rsp_status;
   logic [7:0] rsp_read_byte;

   command_type pending_cmds[$];
   answer_type  expected_answers[$];
   logic [7:0] shadow_frame[PGS * COLS];
   int  failures = 0;
   int  quiet_cycles = 0;
   int  burst_left = 0;
   int  gap_left = 0;
   // Set by the stimulus process: hold commands until the block has answered everything.
   bit  drain_hold = 1'b0;
   bit  stimulus_done = 1'b0;

   page_framebuffer_line_engine u_top (.*);

   always #10 clock = ~clock;

   // Sets or clears one pixel of the shadow frame; off-screen pixels are skipped.
   function automatic bit shadow_plot(int x, int y, bit clr);
      int idx;
      if (x < 0 || y < 0 || x >= COLS || y >= ROWS) return 1'b0;
      idx = (y / 8) * COLS + x;
      if (clr) shadow_frame[idx][y % 8] = 1'b0;
      else     shadow_frame[idx][y % 8] = 1'b1;
      return 1'b1;
   endfunction

   // Straight lines include both ends; diagonal ones step along the major axis with
   // Bresenham error accumulation and then plot the final endpoint.
   function automatic void shadow_line(int x1, int y1, int x2, int y2, bit clr);
      int dx, dy, sx, sy, x, y, err, lo, hi;
      if (x1 == x2) begin
         lo = (y1 < y2) ? y1 : y2;
         hi = (y1 < y2) ? y2 : y1;
         for (int i = lo; i <= hi; i++) void'(shadow_plot(x1, i, clr));
      end else if (y1 == y2) begin
         lo = (x1 < x2) ? x1 : x2;
         hi = (x1 < x2) ? x2 : x1;
         for (int i = lo; i <= hi; i++) void'(shadow_plot(i, y1, clr));
      end else begin
         dx = x2 - x1; dy = y2 - y1;
         sx = dx > 0 ? 1 : -1; sy = dy > 0 ? 1 : -1;
         if (dx < 0) dx = -dx;
         if (dy < 0) dy = -dy;
         x = x1; y = y1; err = 0;
         if (dx > dy) begin
            while (x != x2) begin
               void'(shadow_plot(x, y, clr));
               err += dy;
               if (2 * err >= dx) begin y += sy; err -= dx; end
               x += sx;
            end
         end else begin
            while (y != y2) begin
               void'(shadow_plot(x, y, clr));
               err += dx;
               if (2 * err >= dy) begin x += sx; err -= dy; end
               y += sy;
            end
         end
         void'(shadow_plot(x, y, clr));
      end
   endfunction

   // Applies one command to the shadow frame and returns the answer it must produce.
   function automatic answer_type predict_answer(command_type c);
      answer_type a;
      logic [7:0] keep, data;
      int idx;
      a = '0;
      case (c.action)
         ACT_PIXEL: a.status = !shadow_plot(c.x_start, c.y_start, c.invert);
         ACT_LINE:  shadow_line(c.x_start, c.y_start, c.x_end, c.y_end, c.invert);
         ACT_WRITE, ACT_READ: begin
            if (c.y_start >= PGS || c.x_start >= COLS) begin
               a.status = 1'b1;
            end else begin
               idx = c.y_start * COLS + c.x_start;
               if (c.action == ACT_READ) begin
                  a.read_byte = shadow_frame[idx];
               end else begin
                  // Bits outside bit_low..bit_high are kept; an empty range keeps all.
                  for (int b = 0; b < 8; b++) keep[b] = (b < c.bit_low) || (b > c.bit_high);
                  data = c.invert ? ~c.byte_data : c.byte_data;
                  shadow_frame[idx] = (shadow_frame[idx] & keep) | (data & ~keep);
               end
            end
         end
         ACT_CLEAR: foreach (shadow_frame[i]) shadow_frame[i] = '0;
         default: ;
      endcase
      return a;
   endfunction

   function automatic command_type make_cmd(logic [2:0] act, int xs, int ys, int xe, int ye,
                                            int d, int bl, int bh, bit inv);
      command_type c;
      c.action = act; c.x_start = 8'(xs); c.y_start = 8'(ys); c.x_end = 8'(xe);
      c.y_end = 8'(ye); c.byte_data = 8'(d); c.bit_low = 3'(bl); c.bit_high = 3'(bh);
      c.invert = inv;
      return c;
   endfunction

   // Random command, mostly on screen so that later reads see drawn pixels.
   function automatic command_type random_cmd();
      command_type c;
      int sel;
      c = command_type'(CMD_W'({$urandom, $urandom}));
      sel = $urandom_range(0, 99);
      if (sel < 25)      c.action = ACT_PIXEL;
      else if (sel < 45) c.action = ACT_LINE;
      else if (sel < 65) c.action = ACT_WRITE;
      else if (sel < 93) c.action = ACT_READ;
      else if (sel < 95) c.action = ACT_CLEAR;
      else               c.action = 3'($urandom_range(5, 7));
      if ($urandom_range(0, 9) < 8) begin
         c.x_start = 8'($urandom_range(0, COLS - 1));
         c.x_end   = 8'($urandom_range(0, COLS - 1));
         if (c.action == ACT_WRITE || c.action == ACT_READ)
            c.y_start = 8'($urandom_range(0, PGS - 1));
         else
            c.y_start = 8'($urandom_range(0, ROWS - 1));
         c.y_end = 8'($urandom_range(0, ROWS - 1));
         // Lines are kept short most of the time to keep the run brisk.
         if (c.action == ACT_LINE && $urandom_range(0, 3) != 0) begin
            c.x_end = c.x_start + 8'($urandom_range(0, 16)) - 8'd8;
            c.y_end = c.y_start + 8'($urandom_range(0, 16)) - 8'd8;
            if ($urandom_range(0, 3) == 0) c.y_end = c.y_start;
            else if ($urandom_range(0, 3) == 0) c.x_end = c.x_start;
         end
      end
      return c;
   endfunction

   // Driver: sends queued commands in bursts with random gaps. The expectation is
   // computed at the edge where the transfer happens, so prediction follows block order.
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            expected_answers.push_back(predict_answer(pending_cmds.pop_front()));
            quiet_cycles = 0;
         end
         if (start && !busy || !start) begin
            if (gap_left > 0) gap_left--;
            if (pending_cmds.size() > 0 && gap_left == 0 && !drain_hold &&
                !(drain_hold && expected_answers.size() > 0)) begin
               req_action    <= pending_cmds[0].action;
               req_x_start   <= pending_cmds[0].x_start;
               req_y_start   <= pending_cmds[0].y_start;
               req_x_end     <= pending_cmds[0].x_end;
               req_y_end     <= pending_cmds[0].y_end;
               req_byte_data <= pending_cmds[0].byte_data;
               req_bit_low   <= pending_cmds[0].bit_low;
               req_bit_high  <= pending_cmds[0].bit_high;
               req_invert    <= pending_cmds[0].invert;
               start <= 1'b1;
               if (burst_left > 0) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(0, 12);
                  gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
               end
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // Monitor: every strobed result is matched against the oldest expectation.
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         quiet_cycles = 0;
         if (expected_answers.size() == 0) begin
            $error("unexpected result: status %0d read_byte %0h", rsp_status, rsp_read_byte);
            failures++;
         end else begin
            answer_type e;
            e = expected_answers.pop_front();
            if (rsp_status !== e.status) begin
               $error("status: expected %0d, got %0d", e.status, rsp_status);
               failures++;
            end
            if (rsp_read_byte !== e.read_byte) begin
               $error("read_byte: expected %0h, got %0h", e.read_byte, rsp_read_byte);
               failures++;
            end
         end
      end
   end

   // Watchdog on cycles without any transfer.
   always @(posedge clock) begin
      quiet_cycles++;
      if (quiet_cycles > QUIET_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   initial begin
      foreach (shadow_frame[i]) shadow_frame[i] = '0;
      // Directed part: every action, field extremes, and the listed corner cases.
      pending_cmds.push_back(make_cmd(ACT_READ, 0, 0, 0, 0, 0, 0, 0, 0));
      pending_cmds.push_back(make_cmd(ACT_PIXEL, 0, 0, 255, 255, 255, 7, 7, 0));
      pending_cmds.push_back(make_cmd(ACT_PIXEL, COLS - 1, ROWS - 1, 0, 0, 0, 0, 0, 0));
      pending_cmds.push_back(make_cmd(ACT_PIXEL, 255, 255, 0, 0, 0, 0, 0, 1));   // off screen
      pending_cmds.push_back(make_cmd(ACT_PIXEL, 5, ROWS, 0, 0, 0, 0, 0, 0));   // row off screen
      pending_cmds.push_back(make_cmd(ACT_READ, 0, 0, 0, 0, 0, 0, 0, 0));
      pending_cmds.push_back(make_cmd(ACT_PIXEL, 0, 0, 0, 0, 0, 0, 0, 1));      // clear pixel
      pending_cmds.push_back(make_cmd(ACT_LINE, 3, 255, 3, 0, 0, 0, 0, 0));     // vertical to 255
      pending_cmds.push_back(make_cmd(ACT_LINE, 255, 9, 0, 9, 0, 0, 0, 0));     // horizontal to 255
      pending_cmds.push_back(make_cmd(ACT_LINE, 0, 0, 255, 200, 0, 0, 0, 0));   // shallow diagonal
      pending_cmds.push_back(make_cmd(ACT_LINE, 120, 60, 100, 2, 0, 0, 0, 1));  // steep, clearing
      pending_cmds.push_back(make_cmd(ACT_LINE, 7, 7, 7, 7, 0, 0, 0, 0));       // single point
      pending_cmds.push_back(make_cmd(ACT_READ, 3, 1, 0, 0, 0, 0, 0, 0));
      pending_cmds.push_back(make_cmd(ACT_WRITE, 10, 2, 0, 0, 8'hA5, 0, 7, 0));
      pending_cmds.push_back(make_cmd(ACT_WRITE, 10, 2, 0, 0, 8'h0F, 2, 5, 1));
      pending_cmds.push_back(make_cmd(ACT_WRITE, 10, 2, 0, 0, 8'hFF, 6, 1, 0)); // empty range
      pending_cmds.push_back(make_cmd(ACT_READ, 10, 2, 0, 0, 0, 0, 0, 0));
      pending_cmds.push_back(make_cmd(ACT_WRITE, COLS, 0, 0, 0, 8'hFF, 0, 7, 0));
      pending_cmds.push_back(make_cmd(ACT_WRITE, 0, PGS, 0, 0, 8'hFF, 0, 7, 0));
      pending_cmds.push_back(make_cmd(ACT_READ, 255, 255, 0, 0, 0, 0, 0, 0));
      pending_cmds.push_back(make_cmd(3'd5, 1, 1, 1, 1, 1, 1, 1, 1));
      pending_cmds.push_back(make_cmd(3'd7, 255, 255, 255, 255, 255, 7, 7, 1));
      pending_cmds.push_back(make_cmd(ACT_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0));
      pending_cmds.push_back(make_cmd(ACT_READ, 0, 0, 0, 0, 0, 0, 0, 0));
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      wait (pending_cmds.size() == 0);
      // Let the pipeline run dry once before the random part.
      drain_hold = 1'b1;
      wait (expected_answers.size() == 0);
      @(posedge clock);
      drain_hold = 1'b0;
      for (int i = 0; i < 500; i++) pending_cmds.push_back(random_cmd());
      wait (pending_cmds.size() == 0);
      wait (expected_answers.size() == 0);
      repeat (20) @(posedge clock);
      if (failures == 0 && expected_answers.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

@@ sim.f @@
rtl/pfle_pkg.sv
rtl/page_framebuffer_line_engine.sv
tb/tb_page_framebuffer_line_engine.sv
